@@ sv/tcpbq_pkg.sv @@
`timescale 1ns / 1ps
// shared types and constants of the two-class priority batch queue
// no dependencies

package tcpbq_pkg;

    localparam int WORD_W  = 64;
    localparam int BATCH_W = 7;

    localparam logic MODE_ENQ = 1'b0;
    localparam logic MODE_DEQ = 1'b1;

    typedef enum logic [1:0] {
        KIND_ACK   = 2'd0,
        KIND_ITEM  = 2'd1,
        KIND_EMPTY = 2'd2
    } t_kind;

    typedef struct packed {
        logic               mode;
        logic               is_special;
        logic               joins_batch;
        logic [WORD_W-1:0]  payload_in;
        logic [BATCH_W-1:0] max_batch;
    } t_in_word;

    typedef struct packed {
        t_kind             result_kind;
        logic              accepted;
        logic [WORD_W-1:0] payload_out;
        logic              from_special;
        logic              last;
    } t_out_word;

    typedef struct packed {
        logic enq;
        logic spec_start;
        logic txn_start;
        logic deq_empty;
        logic emit_spec;
        logic emit_txn;
    } t_cmd;

    typedef struct packed {
        logic out_free;
        logic spec_avail;
        logic txn_none;
        logic left_last;
    } t_sts;

endpackage

@@ sv/tcpbq_stream_if.sv @@
`timescale 1ns / 1ps
// valid/ready channel carrying one word of type T
// no dependencies

interface tcpbq_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ sv/tcpbq_ram.sv @@
`timescale 1ns / 1ps
// generic simple dual-port ram, one write port, one registered read port
// no dependencies

module tcpbq_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/tcpbq_ctrl.sv @@
`timescale 1ns / 1ps
// controller state machine: input handshake and drain sequencing
// depends on tcpbq_pkg

module tcpbq_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_in_mode,
    output logic            o_in_ready,
    input  tcpbq_pkg::t_sts i_sts,
    output tcpbq_pkg::t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_SPEC  = 3'b010,
        S_BATCH = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   acc;

    assign o_in_ready = (r_state == S_IDLE) && i_sts.out_free;
    assign acc        = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (acc) begin
                    priority if (i_in_mode == tcpbq_pkg::MODE_ENQ) begin
                        o_cmd.enq = 1'b1;
                    end else if (i_sts.spec_avail) begin
                        o_cmd.spec_start = 1'b1;
                        n_state          = S_SPEC;
                    end else if (i_sts.txn_none) begin
                        o_cmd.deq_empty = 1'b1;
                    end else begin
                        o_cmd.txn_start = 1'b1;
                        n_state         = S_BATCH;
                    end
                end
            end
            S_SPEC: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_spec = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            S_BATCH: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_txn = 1'b1;
                    if (i_sts.left_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ sv/tcpbq_dp.sv @@
`timescale 1ns / 1ps
// datapath: queue pointers, payload rams, batch counter and output register
// depends on tcpbq_pkg and tcpbq_ram

module tcpbq_dp #(
    parameter int SPECIAL_DEPTH = 16,
    parameter int TXN_DEPTH     = 64,
    parameter int PAYLOAD_WIDTH = 64,
    parameter int MAX_BATCH     = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  tcpbq_pkg::t_cmd      i_cmd,
    output tcpbq_pkg::t_sts      o_sts,
    input  tcpbq_pkg::t_in_word  i_in,
    output tcpbq_pkg::t_out_word o_out,
    output logic                 o_out_valid,
    input  logic                 i_out_ready
);

    localparam int SAW = $clog2(SPECIAL_DEPTH);
    localparam int SCW = $clog2(SPECIAL_DEPTH + 1);
    localparam int TAW = $clog2(TXN_DEPTH);
    localparam int TCW = $clog2(TXN_DEPTH + 1);
    localparam int BW  = $clog2(MAX_BATCH + 1);
    localparam int LW  = (TCW > tcpbq_pkg::BATCH_W) ? TCW : tcpbq_pkg::BATCH_W;

    logic [SAW-1:0] r_sp_head, r_sp_tail;
    logic [SCW-1:0] r_sp_count;
    logic [TAW-1:0] r_tx_head, r_tx_tail;
    logic [TCW-1:0] r_tx_count;
    logic           r_batch_spec;
    logic [BW-1:0]  r_left;

    tcpbq_pkg::t_out_word r_out;
    logic                 r_out_valid;

    logic                     cls;
    logic                     sp_full, tx_full;
    logic                     sp_we, tx_we, sp_re, tx_re;
    logic [PAYLOAD_WIDTH-1:0] wdata, sp_rdata, tx_rdata;
    logic [LW-1:0]            want, cap, cnt, n_lw;
    logic [BW-1:0]            n_take;
    logic                     load;
    logic                     left_last;
    logic [tcpbq_pkg::WORD_W-1:0] sp_word, tx_word;
    logic [SAW-1:0]           sp_head_inc, sp_tail_inc;
    logic [TAW-1:0]           tx_head_inc, tx_tail_inc;

    assign cls     = i_in.joins_batch ? r_batch_spec : i_in.is_special;
    assign sp_full = (r_sp_count == SCW'(SPECIAL_DEPTH));
    assign tx_full = (r_tx_count == TCW'(TXN_DEPTH));
    assign wdata   = i_in.payload_in[PAYLOAD_WIDTH-1:0];
    assign sp_we   = i_cmd.enq && cls && !sp_full;
    assign tx_we   = i_cmd.enq && !cls && !tx_full;
    assign sp_re   = i_cmd.spec_start;
    assign left_last = (r_left == BW'(1));
    assign tx_re   = i_cmd.txn_start || (i_cmd.emit_txn && !left_last);

    assign sp_head_inc = (r_sp_head == SAW'(SPECIAL_DEPTH - 1)) ? '0 : r_sp_head + 1'b1;
    assign sp_tail_inc = (r_sp_tail == SAW'(SPECIAL_DEPTH - 1)) ? '0 : r_sp_tail + 1'b1;
    assign tx_head_inc = (r_tx_head == TAW'(TXN_DEPTH - 1)) ? '0 : r_tx_head + 1'b1;
    assign tx_tail_inc = (r_tx_tail == TAW'(TXN_DEPTH - 1)) ? '0 : r_tx_tail + 1'b1;

    assign want   = LW'(i_in.max_batch);
    assign cap    = (want > LW'(MAX_BATCH)) ? LW'(MAX_BATCH) : want;
    assign cnt    = LW'(r_tx_count);
    assign n_lw   = (cap > cnt) ? cnt : cap;
    assign n_take = n_lw[BW-1:0];

    always_comb begin
        sp_word = '0;
        tx_word = '0;
        sp_word[PAYLOAD_WIDTH-1:0] = sp_rdata;
        tx_word[PAYLOAD_WIDTH-1:0] = tx_rdata;
    end

    tcpbq_ram #(.WIDTH(PAYLOAD_WIDTH), .DEPTH(SPECIAL_DEPTH)) u_sp_ram (
        .i_clk   (i_clk),
        .i_we    (sp_we),
        .i_waddr (r_sp_tail),
        .i_wdata (wdata),
        .i_re    (sp_re),
        .i_raddr (r_sp_head),
        .o_rdata (sp_rdata)
    );

    tcpbq_ram #(.WIDTH(PAYLOAD_WIDTH), .DEPTH(TXN_DEPTH)) u_tx_ram (
        .i_clk   (i_clk),
        .i_we    (tx_we),
        .i_waddr (r_tx_tail),
        .i_wdata (wdata),
        .i_re    (tx_re),
        .i_raddr (r_tx_head),
        .o_rdata (tx_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp_head    <= '0;
            r_sp_tail    <= '0;
            r_sp_count   <= '0;
            r_tx_head    <= '0;
            r_tx_tail    <= '0;
            r_tx_count   <= '0;
            r_batch_spec <= 1'b0;
            r_left       <= '0;
        end else begin
            if (i_cmd.enq && !i_in.joins_batch) begin
                r_batch_spec <= i_in.is_special;
            end
            if (sp_we) begin
                r_sp_tail  <= sp_tail_inc;
                r_sp_count <= r_sp_count + 1'b1;
            end
            if (sp_re) begin
                r_sp_head  <= sp_head_inc;
                r_sp_count <= r_sp_count - 1'b1;
            end
            if (tx_we) begin
                r_tx_tail  <= tx_tail_inc;
                r_tx_count <= r_tx_count + 1'b1;
            end
            if (tx_re) begin
                r_tx_head <= tx_head_inc;
            end
            if (i_cmd.txn_start) begin
                r_tx_count <= r_tx_count - TCW'(n_take);
                r_left     <= n_take;
            end else if (i_cmd.emit_txn) begin
                r_left <= r_left - 1'b1;
            end
        end
    end

    // output word register
    assign load = i_cmd.enq || i_cmd.deq_empty || i_cmd.emit_spec || i_cmd.emit_txn;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out.accepted     <= 1'b0;
            r_out.payload_out  <= '0;
            r_out.from_special <= 1'b0;
            r_out.last         <= 1'b1;
            priority if (i_cmd.enq) begin
                r_out.result_kind <= tcpbq_pkg::KIND_ACK;
                r_out.accepted    <= sp_we || tx_we;
            end else if (i_cmd.deq_empty) begin
                r_out.result_kind <= tcpbq_pkg::KIND_EMPTY;
            end else if (i_cmd.emit_spec) begin
                r_out.result_kind  <= tcpbq_pkg::KIND_ITEM;
                r_out.payload_out  <= sp_word;
                r_out.from_special <= 1'b1;
            end else begin
                r_out.result_kind <= tcpbq_pkg::KIND_ITEM;
                r_out.payload_out <= tx_word;
                r_out.last        <= left_last;
            end
        end
    end

    assign o_out       = r_out;
    assign o_out_valid = r_out_valid;

    assign o_sts.out_free   = !r_out_valid || i_out_ready;
    assign o_sts.spec_avail = (r_sp_count != '0);
    assign o_sts.txn_none   = (n_take == '0);
    assign o_sts.left_last  = left_last;

endmodule

@@ sv/two_class_priority_batch_queue.sv @@
`timescale 1ns / 1ps
// top level of the two-class priority batch queue
// depends on tcpbq_pkg, tcpbq_stream_if, tcpbq_ctrl, tcpbq_dp, tcpbq_ram

// An enqueue word is taken every cycle while the output is not held back,
// and its acknowledgement appears in the output register in the cycle after
// acceptance. A dequeue that finds a special message reads it through the
// registered read port of the special ram into the single output register;
// a batch dequeue of n transactions reads its first word the same way, then
// gives one word per cycle while the output is not held back, and holds the
// input until the last word is loaded. A dequeue that returns nothing gives
// its empty marker in the cycle after acceptance.

module two_class_priority_batch_queue #(
    parameter int SPECIAL_DEPTH = 16,
    parameter int TXN_DEPTH     = 64,
    parameter int PAYLOAD_WIDTH = 64,
    parameter int MAX_BATCH     = 64
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    tcpbq_stream_if.sink   i_in,
    tcpbq_stream_if.source o_out
);

    tcpbq_pkg::t_cmd      cmd;
    tcpbq_pkg::t_sts      sts;
    tcpbq_pkg::t_in_word  in_word;
    tcpbq_pkg::t_out_word out_word;
    logic                 in_ready;
    logic                 out_valid;

    assign in_word = i_in.data;

    tcpbq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_mode  (in_word.mode),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    tcpbq_dp #(
        .SPECIAL_DEPTH (SPECIAL_DEPTH),
        .TXN_DEPTH     (TXN_DEPTH),
        .PAYLOAD_WIDTH (PAYLOAD_WIDTH),
        .MAX_BATCH     (MAX_BATCH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in        (in_word),
        .o_out       (out_word),
        .o_out_valid (out_valid),
        .i_out_ready (o_out.ready)
    );

    assign i_in.ready  = in_ready;
    assign o_out.valid = out_valid;
    assign o_out.data  = out_word;

endmodule
